// ===== design/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, action codes, payload structs and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int unsigned COLUMNS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT    = 25;

  localparam logic [7:0] BLANK_ATTR_RESET = 8'h0F;
  localparam logic [7:0] SPACE_CODE       = 8'h20;
  localparam logic [7:0] NEWLINE_CODE     = 8'h0A;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration port: register index sits above the byte offset.
  localparam int unsigned PADDR_W        = 3;
  localparam logic        REG_BLANK_ATTR = 1'b0;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] character;
    logic [7:0] color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [4:0] cursor_row;
    logic [6:0] cursor_col;
    logic [7:0] read_char;
    logic [7:0] read_color;
    logic       scrolled;
  } result_t;

  typedef struct packed {
    logic load;       // capture the input beat
    logic ptr_clr;    // restart the sweep pointer
    logic ptr_inc;    // advance the sweep pointer
    logic copy;       // move one cell up by a row
    logic fill;       // write a blank cell at the pointer
    logic fill_init;  // blank with the reset attribute
    logic scroll_set; // cursor to start of last row, mark scroll
    logic home;       // cursor to the first cell
    logic put;        // write the character or take the newline
    logic finish;     // capture the result
  } cmd_t;

  typedef struct packed {
    logic op_put;
    logic op_clear;
    logic op_read;
    logic at_end;
    logic ptr_copy_end;
    logic ptr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/tcw_ctrl.sv =====
// ----------------------------------------------------------------------------
// Text console controller
// Sequences the reset sweep, scroll, clear, put and read operations.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  output logic               done,
  input  wire tcw_pkg::sts_t sts,
  output tcw_pkg::cmd_t      cmd
);

  localparam logic [3:0] S_INIT        = 4'd0;
  localparam logic [3:0] S_IDLE        = 4'd1;
  localparam logic [3:0] S_DECODE      = 4'd2;
  localparam logic [3:0] S_SCROLL_COPY = 4'd3;
  localparam logic [3:0] S_SCROLL_FILL = 4'd4;
  localparam logic [3:0] S_PUT         = 4'd5;
  localparam logic [3:0] S_CLEAR       = 4'd6;
  localparam logic [3:0] S_READ        = 4'd7;
  localparam logic [3:0] S_DONE        = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_DONE);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_INIT: begin
        cmd.fill      = 1'b1;
        cmd.fill_init = 1'b1;
        cmd.ptr_inc   = 1'b1;
        if (sts.ptr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.op_put) begin
          if (sts.at_end) begin
            cmd.scroll_set = 1'b1;
            cmd.ptr_clr    = 1'b1;
            state_next     = S_SCROLL_COPY;
          end else begin
            state_next = S_PUT;
          end
        end else if (sts.op_clear) begin
          cmd.home    = 1'b1;
          cmd.ptr_clr = 1'b1;
          state_next  = S_CLEAR;
        end else if (sts.op_read) begin
          state_next = S_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SCROLL_COPY: begin
        cmd.copy = 1'b1;
        if (sts.ptr_copy_end) begin
          state_next = S_SCROLL_FILL;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_SCROLL_FILL: begin
        cmd.fill    = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        cmd.put    = 1'b1;
        state_next = S_DONE;
      end
      S_CLEAR: begin
        cmd.fill    = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (sts.ptr_last) begin
          state_next = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_DONE)
    else $error("result strobe without a finishing step");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_DECODE)
    else $error("accepted beat was not decoded");

  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // After a scroll the cursor must sit on the last row before the write.
  a_put_inside_screen: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |-> !sts.at_end)
    else $error("character write with the cursor past the screen");

endmodule

`default_nettype wire

// ===== design/tcw_datapath.sv =====
// ----------------------------------------------------------------------------
// Text console datapath
// Screen store, cursor, sweep pointer, item and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcw_pkg::cmd_t    cmd,
  output tcw_pkg::sts_t         sts,
  input  wire tcw_pkg::item_t   item,
  input  wire logic [7:0]       blank_attribute,
  output tcw_pkg::result_t      result
);

  localparam int unsigned CELLS = ROWS * COLUMNS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  tcw_pkg::item_t item_q;
  logic           read_ok;
  logic [RW-1:0]  row;
  logic [CW-1:0]  col;
  logic           scrolled;
  logic [AW-1:0]  ptr;

  logic           we;
  logic [AW-1:0]  waddr;
  logic [15:0]    wdata;
  logic [AW-1:0]  raddr;
  logic [15:0]    rdata;
  logic [AW:0]    cur_sum;
  logic [AW:0]    rd_sum;
  logic [AW:0]    copy_sum;
  logic [15:0]    blank_cell;
  logic           is_newline;

  assign is_newline = (item_q.character == tcw_pkg::NEWLINE_CODE);
  assign cur_sum    = (AW+1)'(row) * (AW+1)'(COLUMNS) + (AW+1)'(col);
  assign rd_sum     = (AW+1)'(item_q.read_row) * (AW+1)'(COLUMNS)
                    + (AW+1)'(item_q.read_col);
  assign copy_sum   = (AW+1)'(ptr) + (AW+1)'(COLUMNS);
  assign blank_cell = {cmd.fill_init ? tcw_pkg::BLANK_ATTR_RESET : blank_attribute,
                       tcw_pkg::SPACE_CODE};

  always_comb begin
    we    = 1'b0;
    waddr = ptr;
    wdata = blank_cell;
    if (cmd.fill) begin
      we = 1'b1;
    end else if (cmd.copy) begin
      // Reads run one cell ahead of writes; the first cycle only reads.
      we    = (ptr != '0);
      waddr = ptr - AW'(1);
      wdata = rdata;
    end else if (cmd.put) begin
      we    = !is_newline;
      waddr = cur_sum[AW-1:0];
      wdata = {item_q.color, item_q.character};
    end
  end

  assign raddr = cmd.copy ? copy_sum[AW-1:0] : rd_sum[AW-1:0];

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      scrolled <= 1'b0;
      ptr      <= '0;
    end else begin
      if (cmd.ptr_clr) begin
        ptr <= '0;
      end else if (cmd.ptr_inc) begin
        ptr <= ptr + AW'(1);
      end
      if (cmd.load) begin
        scrolled <= 1'b0;
      end
      if (cmd.home) begin
        row <= '0;
        col <= '0;
      end else if (cmd.scroll_set) begin
        row      <= RW'(ROWS - 1);
        col      <= '0;
        scrolled <= 1'b1;
      end else if (cmd.put) begin
        if (is_newline || (32'(col) == COLUMNS - 1)) begin
          row <= row + RW'(1);
          col <= '0;
        end else begin
          col <= col + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_q  <= item;
      read_ok <= (32'(item.read_row) < ROWS) && (32'(item.read_col) < COLUMNS);
    end
    if (cmd.finish) begin
      result.cursor_row <= 5'(row);
      result.cursor_col <= 7'(col);
      result.scrolled   <= scrolled;
      if ((item_q.action == tcw_pkg::ACT_READ) && read_ok) begin
        result.read_char  <= rdata[7:0];
        result.read_color <= rdata[15:8];
      end else begin
        result.read_char  <= '0;
        result.read_color <= '0;
      end
    end
  end

  assign sts.op_put       = (item_q.action == tcw_pkg::ACT_PUT) && (item_q.character != '0);
  assign sts.op_clear     = (item_q.action == tcw_pkg::ACT_CLEAR);
  assign sts.op_read      = (item_q.action == tcw_pkg::ACT_READ);
  assign sts.at_end       = (32'(row) == ROWS);
  assign sts.ptr_copy_end = (ptr == AW'(CELLS - COLUMNS));
  assign sts.ptr_last     = (ptr == AW'(CELLS - 1));

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console with a ROWS by COLUMNS screen store and a cursor.
// ----------------------------------------------------------------------------
// Commands are taken on start while busy is low: put a character, clear the
// screen or read one cell. Every beat yields one result, shown on result for
// exactly one cycle with done high; the receiver cannot stall it, so it must
// take the result in that cycle.
// A plain put, a newline or a read steps from the decode state through its
// own state to the done state; a zero character or the unused action goes
// from decode straight to done. A clear sweeps the store once, one cell a
// cycle. A put that finds the cursor past the last row first scrolls: one
// pass of cell copies, read one row ahead and written behind, then the blank
// last row. Each sweep writes one cell at a time through the store's single
// write port. One beat is in flight at a time. After reset the store,
// ROWS*COLUMNS cells (2000 by default), is blanked with attribute 0Fh, one
// cell a cycle, and busy stays high during the sweep. The user is to write
// the blank attribute register over the APB port only while the block is
// idle, not enforced by the block; it affects only later clears and scrolls.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
  parameter int unsigned COLUMNS = tcw_pkg::COLUMNS_DEFAULT,
  parameter int unsigned ROWS    = tcw_pkg::ROWS_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire tcw_pkg::item_t               item,
  output logic                              done,
  output tcw_pkg::result_t                  result,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tcw_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);

  logic [7:0]    blank_attribute;
  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;
  logic          reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[tcw_pkg::PADDR_W-1] == tcw_pkg::REG_BLANK_ATTR);
  assign prdata  = reg_hit ? {24'd0, blank_attribute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_attribute <= tcw_pkg::BLANK_ATTR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      blank_attribute <= pwdata[7:0];
    end
  end

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .sts   (sts),
    .cmd   (cmd)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .item            (item),
    .blank_attribute (blank_attribute),
    .result          (result)
  );

endmodule

`default_nettype wire
